/* sv/ddo_pkg.sv */
// ----------------------------------------------------------------------------
// ddo_pkg
// Shared types and angle constants for the differential drive odometry core.
// ----------------------------------------------------------------------------
package ddo_pkg;

  // angles are signed Q3.28 radians
  localparam logic signed [32:0] PI_Q      = 33'sd843314857;
  localparam logic signed [32:0] HALF_PI_Q = 33'sd421657428;
  localparam logic signed [32:0] TWO_PI_S  = 33'sd1686629713;
  localparam logic        [31:0] TWO_PI_Q  = 32'd1686629713;
  // floor(2^47 / 2pi), quotient estimate for the digit-wise modulo reduction
  localparam logic        [16:0] MOD_RECIP = 17'((64'd1 << 47) / 64'd1686629713);
  // cordic gain compensation, Q2.30
  localparam logic signed [33:0] CORDIC_K  = 34'sd652032874;

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_LEFT_SCALE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RIGHT_SCALE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INV_TRACK   = 2'd2;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [30:0] heading;
  } pose_load_t;

  // arctangent of 2^-i in Q3.28
  function automatic logic signed [32:0] atan_step(input int i);
    logic signed [32:0] v;
    v = '0;
    case (i)
      0:       v = 33'sd210828714;
      1:       v = 33'sd124459457;
      2:       v = 33'sd65760959;
      3:       v = 33'sd33381290;
      4:       v = 33'sd16755422;
      5:       v = 33'sd8385879;
      6:       v = 33'sd4193963;
      7:       v = 33'sd2097109;
      8:       v = 33'sd1048571;
      9:       v = 33'sd524287;
      default: begin
        if (i <= 28) v = 33'sd1 <<< (28 - i);
        else v = '0;
      end
    endcase
    return v;
  endfunction

endpackage

/* sv/differential_drive_odometry_core.sv */
// update command, at default parameters: the pose multiplies wait on the cordic, then follow
// three 16-bit digit multiplies, a four-digit modulo-2pi reduction and the heading wrap steps
// one command is executed at a time, a two-word queue buffers input
// reset: synchronous, clears the pose, the configuration registers, queue and result valid
// ----------------------------------------------------------------------------
// differential_drive_odometry_core
// Dead-reckoning pose tracker for a two-wheel base, with configuration port.
// ----------------------------------------------------------------------------
module differential_drive_odometry_core #(
  parameter int COUNT_WIDTH   = 16,
  parameter int POSE_WIDTH    = 32,
  parameter int CORDIC_STAGES = 24
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [ddo_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [31:0]                      cfg_data,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic                             command,
  input  logic signed [COUNT_WIDTH-1:0]    left_count,
  input  logic signed [COUNT_WIDTH-1:0]    right_count,
  input  logic signed [31:0]               load_x,
  input  logic signed [31:0]               load_y,
  input  logic signed [30:0]               load_heading,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic signed [31:0]               pos_x,
  output logic signed [31:0]               pos_y,
  output logic signed [30:0]               heading
);
  import ddo_pkg::*;

  logic [23:0]                   left_scale;
  logic [23:0]                   right_scale;
  logic [31:0]                   inv_track;
  logic                          q_valid;
  logic                          q_take;
  logic                          q_is_load;
  logic signed [COUNT_WIDTH-1:0] q_left;
  logic signed [COUNT_WIDTH-1:0] q_right;
  pose_load_t                    q_load;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      left_scale  <= '0;
      right_scale <= '0;
      inv_track   <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_LEFT_SCALE:  left_scale  <= cfg_data[23:0];
        REG_RIGHT_SCALE: right_scale <= cfg_data[23:0];
        REG_INV_TRACK:   inv_track   <= cfg_data;
        default: ;
      endcase
    end
  end

  ddo_front #(.COUNT_WIDTH(COUNT_WIDTH)) u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .command      (command),
    .left_count   (left_count),
    .right_count  (right_count),
    .load_x       (load_x),
    .load_y       (load_y),
    .load_heading (load_heading),
    .q_valid      (q_valid),
    .q_take       (q_take),
    .q_is_load    (q_is_load),
    .q_left       (q_left),
    .q_right      (q_right),
    .q_load       (q_load)
  );

  ddo_back #(
    .COUNT_WIDTH   (COUNT_WIDTH),
    .POSE_WIDTH    (POSE_WIDTH),
    .CORDIC_STAGES (CORDIC_STAGES)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .left_scale  (left_scale),
    .right_scale (right_scale),
    .inv_track   (inv_track),
    .q_valid     (q_valid),
    .q_take      (q_take),
    .q_is_load   (q_is_load),
    .q_left      (q_left),
    .q_right     (q_right),
    .q_load      (q_load),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .pos_x       (pos_x),
    .pos_y       (pos_y),
    .heading     (heading)
  );

endmodule

/* sv/ddo_front.sv */
// ----------------------------------------------------------------------------
// ddo_front
// Accepts command words, decodes them and holds them in a two-entry queue.
// ----------------------------------------------------------------------------
module ddo_front #(
  parameter int COUNT_WIDTH = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          command,
  input  logic signed [COUNT_WIDTH-1:0] left_count,
  input  logic signed [COUNT_WIDTH-1:0] right_count,
  input  logic signed [31:0]            load_x,
  input  logic signed [31:0]            load_y,
  input  logic signed [30:0]            load_heading,
  output logic                          q_valid,
  input  logic                          q_take,
  output logic                          q_is_load,
  output logic signed [COUNT_WIDTH-1:0] q_left,
  output logic signed [COUNT_WIDTH-1:0] q_right,
  output ddo_pkg::pose_load_t           q_load
);
  import ddo_pkg::*;

  logic                          ent_is_load [2];
  logic signed [COUNT_WIDTH-1:0] ent_left    [2];
  logic signed [COUNT_WIDTH-1:0] ent_right   [2];
  pose_load_t                    ent_pose    [2];
  logic                          wr_ptr;
  logic                          rd_ptr;
  logic [1:0]                    count;
  logic                          push;
  logic                          pop;

  assign in_ready  = (count != 2'd2);
  assign push      = in_valid && in_ready;
  assign q_valid   = (count != 2'd0);
  assign pop       = q_take && q_valid;
  assign q_is_load = ent_is_load[rd_ptr];
  assign q_left    = ent_left[rd_ptr];
  assign q_right   = ent_right[rd_ptr];
  assign q_load    = ent_pose[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      ent_is_load[wr_ptr] <= command;
      // left wheel counts the other way; negation wraps in count width
      ent_left[wr_ptr]    <= COUNT_WIDTH'(-left_count);
      ent_right[wr_ptr]   <= right_count;
      ent_pose[wr_ptr]    <= '{x: load_x, y: load_y, heading: load_heading};
    end
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      count <= count + 2'(push) - 2'(pop);
    end
  end

endmodule

/* sv/ddo_cordic.sv */
// ----------------------------------------------------------------------------
// ddo_cordic
// Iterative rotation-mode cordic, one micro-rotation per cycle, giving cos/sin.
// ----------------------------------------------------------------------------
module ddo_cordic #(
  parameter int CORDIC_STAGES = 24
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [30:0] angle,
  output logic               done,
  output logic signed [33:0] cos_out,
  output logic signed [33:0] sin_out
);
  import ddo_pkg::*;

  localparam int IW = $clog2(CORDIC_STAGES + 1);

  logic              busy;
  logic [IW-1:0]     iter;
  logic signed [33:0] xr;
  logic signed [33:0] yr;
  logic signed [32:0] zr;
  logic              flip;
  logic signed [32:0] ang_ext;
  logic signed [32:0] z_fold;
  logic              flip_fold;
  logic signed [32:0] atan_i;

  // one fold by pi brings any 31-bit angle into +-pi/2
  always_comb begin
    ang_ext   = 33'(angle);
    z_fold    = ang_ext;
    flip_fold = 1'b0;
    if (ang_ext > HALF_PI_Q) begin
      z_fold    = ang_ext - PI_Q;
      flip_fold = 1'b1;
    end else if (ang_ext < -HALF_PI_Q) begin
      z_fold    = ang_ext + PI_Q;
      flip_fold = 1'b1;
    end
    atan_i = atan_step(int'(iter));
  end

  assign cos_out = flip ? -xr : xr;
  assign sin_out = flip ? -yr : yr;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      iter <= '0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
      iter <= '0;
      xr   <= CORDIC_K;
      yr   <= '0;
      zr   <= z_fold;
      flip <= flip_fold;
    end else if (busy) begin
      if (zr >= 0) begin
        xr <= xr - (yr >>> iter);
        yr <= yr + (xr >>> iter);
        zr <= zr - atan_i;
      end else begin
        xr <= xr + (yr >>> iter);
        yr <= yr - (xr >>> iter);
        zr <= zr + atan_i;
      end
      iter <= iter + 1'b1;
      if (iter == IW'(CORDIC_STAGES - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  assert property (@(posedge clk) disable iff (rst) start |=> !done)
    else $error("cordic done held across a new start");
  assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("cordic done while still iterating");
  assert property (@(posedge clk) disable iff (rst) (busy && !start) |=> (busy || done))
    else $error("cordic dropped an operation");

endmodule

/* sv/ddo_back.sv */
// ----------------------------------------------------------------------------
// ddo_back
// Executes queued commands: pose load, or wheel scaling, pose advance and heading update.
// ----------------------------------------------------------------------------
module ddo_back #(
  parameter int COUNT_WIDTH   = 16,
  parameter int POSE_WIDTH    = 32,
  parameter int CORDIC_STAGES = 24
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [23:0]                   left_scale,
  input  logic [23:0]                   right_scale,
  input  logic [31:0]                   inv_track,
  input  logic                          q_valid,
  output logic                          q_take,
  input  logic                          q_is_load,
  input  logic signed [COUNT_WIDTH-1:0] q_left,
  input  logic signed [COUNT_WIDTH-1:0] q_right,
  input  ddo_pkg::pose_load_t           q_load,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [31:0]            pos_x,
  output logic signed [31:0]            pos_y,
  output logic signed [30:0]            heading
);
  import ddo_pkg::*;

  localparam int DW  = COUNT_WIDTH + 25;          // signed distance width
  localparam int NCH = (DW - 1 + 15) / 16;        // 16-bit digits of |distance|
  localparam int AC  = NCH * 16;
  localparam int PW  = AC + 32;                   // product width
  localparam int QW  = PW - 20;
  localparam int NQ  = (QW + 15) / 16;            // 16-bit digits of the heading product
  localparam int QA  = NQ * 16;
  localparam int CW  = $clog2(NCH + 1);
  localparam int BW  = $clog2(NQ + 1);
  localparam logic [PW-1:0] RND35 = PW'(1) << 34;
  localparam logic [PW-1:0] RND20 = PW'(1) << 19;
  localparam logic [32:0] MOD_M1 = 33'(TWO_PI_Q);
  localparam logic [32:0] MOD_M2 = MOD_M1 << 1;
  localparam logic signed [63:0] PMAX = (64'sd1 <<< (POSE_WIDTH - 1)) - 64'sd1;
  localparam logic signed [63:0] PMIN = -(64'sd1 <<< (POSE_WIDTH - 1));

  typedef enum logic [3:0] {
    S_IDLE, S_SCL, S_SCR, S_PREP, S_MLD, S_MUL, S_RND, S_ACC,
    S_MQ, S_MR, S_MC, S_HSUM, S_WRAP, S_DONE
  } state_t;

  typedef enum logic [1:0] {SEL_X, SEL_Y, SEL_H} sel_t;

  state_t                         state;
  sel_t                           sel;
  logic signed [COUNT_WIDTH-1:0]  lc_r;
  logic signed [COUNT_WIDTH-1:0]  rc_r;
  logic signed [DW-1:0]           dl;
  logic signed [DW-1:0]           dr;
  logic signed [DW-1:0]           distance;
  logic signed [DW-1:0]           diff;
  logic signed [DW-1:0]           sc_a;
  logic signed [DW-1:0]           sc_b;
  logic signed [DW-1:0]           sc_prod;
  logic [AC-1:0]                  a_sh;
  logic [31:0]                    b_op;
  logic [PW-1:0]                  acc;
  logic [47:0]                    pp;
  logic [CW-1:0]                  mcnt;
  logic                           neg;
  logic signed [63:0]             step;
  logic [QA-1:0]                  q_sh;
  logic [BW-1:0]                  bcnt;
  logic [30:0]                    rem;
  logic [46:0]                    mod_in;
  logic [46:0]                    mod_t;
  logic [48:0]                    mod_qp;
  logic [16:0]                    q_est;
  logic [46:0]                    mod_sub;
  logic [32:0]                    mod_r;
  logic [32:0]                    rem_fix;
  logic signed [32:0]             h;
  logic signed [POSE_WIDTH-1:0]   x_reg;
  logic signed [POSE_WIDTH-1:0]   y_reg;
  logic signed [30:0]             heading_reg;
  logic                           cordic_start;
  logic                           cordic_done;
  logic signed [33:0]             cos_v;
  logic signed [33:0]             sin_v;
  logic signed [33:0]             trig;
  logic [DW-1:0]                  dist_mag;
  logic [DW-1:0]                  diff_mag;
  logic [33:0]                    trig_mag;
  logic [63:0]                    rnd_mag;
  logic signed [63:0]             pose_sum;

  function automatic logic signed [POSE_WIDTH-1:0] sat(input logic signed [63:0] v);
    logic signed [63:0] r;
    r = v;
    if (v > PMAX) r = PMAX;
    else if (v < PMIN) r = PMIN;
    return POSE_WIDTH'(r);
  endfunction

  ddo_cordic #(.CORDIC_STAGES(CORDIC_STAGES)) u_cordic (
    .clk     (clk),
    .rst     (rst),
    .start   (cordic_start),
    .angle   (heading_reg),
    .done    (cordic_done),
    .cos_out (cos_v),
    .sin_out (sin_v)
  );

  assign q_take       = (state == S_IDLE) && q_valid;
  assign cordic_start = q_take && !q_is_load;

  always_comb begin
    sc_a     = (state == S_SCL) ? DW'(lc_r) : DW'(rc_r);
    sc_b     = (state == S_SCL) ? $signed(DW'({1'b0, left_scale}))
                                : $signed(DW'({1'b0, right_scale}));
    sc_prod  = sc_a * sc_b;
    dist_mag = distance[DW-1] ? DW'(-distance) : DW'(distance);
    diff_mag = diff[DW-1] ? DW'(-diff) : DW'(diff);
    trig     = (sel == SEL_X) ? cos_v : sin_v;
    trig_mag = trig[33] ? 34'(-trig) : 34'(trig);
    pp       = 48'(a_sh[AC-1 -: 16]) * 48'(b_op);
    rnd_mag  = 64'((acc + RND35) >> 35);
    pose_sum = ((sel == SEL_X) ? 64'(x_reg) : 64'(y_reg)) + step;
    // modulo 2pi one 16-bit digit at a time: quotient estimate is low by at most two
    mod_in   = {rem, q_sh[QA-1 -: 16]};
    mod_qp   = 49'(mod_in[46:15]) * 49'(MOD_RECIP);
    mod_sub  = mod_t - 47'(q_est) * 47'(TWO_PI_Q);
    rem_fix  = mod_r;
    if (mod_r >= MOD_M2) rem_fix = mod_r - MOD_M2;
    else if (mod_r >= MOD_M1) rem_fix = mod_r - MOD_M1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      sel         <= SEL_X;
      out_valid   <= 1'b0;
      x_reg       <= '0;
      y_reg       <= '0;
      heading_reg <= '0;
    end else begin
      if (out_valid && out_ready && state != S_DONE) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (q_valid) begin
            if (q_is_load) begin
              x_reg       <= sat(64'(q_load.x));
              y_reg       <= sat(64'(q_load.y));
              heading_reg <= q_load.heading;
              state       <= S_DONE;
            end else begin
              lc_r  <= q_left;
              rc_r  <= q_right;
              state <= S_SCL;
            end
          end
        end
        S_SCL: begin
          dl    <= sc_prod;
          state <= S_SCR;
        end
        S_SCR: begin
          dr    <= sc_prod;
          state <= S_PREP;
        end
        S_PREP: begin
          distance <= dl + dr;
          diff     <= dr - dl;
          sel      <= SEL_X;
          state    <= S_MLD;
        end
        S_MLD: begin
          acc  <= '0;
          mcnt <= '0;
          if (sel == SEL_H) begin
            a_sh  <= AC'(diff_mag);
            b_op  <= inv_track;
            neg   <= diff[DW-1];
            state <= S_MUL;
          end else if (cordic_done) begin
            a_sh  <= AC'(dist_mag);
            b_op  <= trig_mag[31:0];
            neg   <= distance[DW-1] ^ trig[33];
            state <= S_MUL;
          end
        end
        S_MUL: begin
          // digit-serial multiply, most significant digit first
          acc  <= (acc << 16) + PW'(pp);
          a_sh <= a_sh << 16;
          mcnt <= mcnt + 1'b1;
          if (mcnt == CW'(NCH - 1)) state <= S_RND;
        end
        S_RND: begin
          if (sel == SEL_H) begin
            q_sh  <= QA'((acc + RND20) >> 20);
            rem   <= '0;
            bcnt  <= '0;
            state <= S_MQ;
          end else begin
            step  <= neg ? -$signed(rnd_mag) : $signed(rnd_mag);
            state <= S_ACC;
          end
        end
        S_ACC: begin
          if (sel == SEL_X) begin
            x_reg <= sat(pose_sum);
            sel   <= SEL_Y;
          end else begin
            y_reg <= sat(pose_sum);
            sel   <= SEL_H;
          end
          state <= S_MLD;
        end
        S_MQ: begin
          mod_t <= mod_in;
          q_est <= mod_qp[48:32];
          q_sh  <= q_sh << 16;
          state <= S_MR;
        end
        S_MR: begin
          mod_r <= mod_sub[32:0];
          state <= S_MC;
        end
        S_MC: begin
          rem  <= rem_fix[30:0];
          bcnt <= bcnt + 1'b1;
          if (bcnt == BW'(NQ - 1)) state <= S_HSUM;
          else state <= S_MQ;
        end
        S_HSUM: begin
          h     <= 33'(heading_reg) + (neg ? -$signed({2'b0, rem}) : $signed({2'b0, rem}));
          state <= S_WRAP;
        end
        S_WRAP: begin
          if (h > PI_Q) begin
            h <= h - TWO_PI_S;
          end else if (h < -PI_Q) begin
            h <= h + TWO_PI_S;
          end else begin
            heading_reg <= h[30:0];
            state       <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            pos_x     <= 32'(x_reg);
            pos_y     <= 32'(y_reg);
            heading   <= heading_reg;
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    (state == S_MUL && sel != SEL_H) |-> cordic_done)
    else $error("position multiply started before cordic finished");
  assert property (@(posedge clk) disable iff (rst) (state == S_MC) |=> (rem < TWO_PI_Q))
    else $error("heading remainder out of range");
  assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && (!out_valid || out_ready)) |=> out_valid)
    else $error("result word not presented");
  assert property (@(posedge clk) disable iff (rst) $rose(out_valid) |-> $past(state == S_DONE))
    else $error("result word appeared outside completion");

endmodule
